/* sv/dms_pkg.sv */
// Shared types and constants for the detour duration statistics block.
// No dependencies; used by every module of the block.
`default_nettype none
package dms_pkg;

    localparam int DUR_W   = 24;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 34;
    localparam int SQ_W    = 58;
    localparam int ELA_W   = 48;
    localparam int TPS_W   = 34;
    localparam int WIDE_W  = 144;
    localparam int HALF_W  = 72;
    localparam int ALU_STEPS = 72;

    localparam logic [TPS_W-1:0] TPS_RESET = 34'd1000000000;
    // 1e6 * 65536, its square, and 100 * 65536
    localparam logic [HALF_W-1:0] USEC_SCALE    = 72'd65536000000;
    localparam logic [HALF_W-1:0] USEC_SCALE_SQ = 72'd4294967296000000000000;
    localparam logic [HALF_W-1:0] PCT_SCALE     = 72'd6553600;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } alu_op_t;

    // closed run handed from front to back
    typedef struct packed {
        logic             ovf;
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] s;
        logic [SQ_W-1:0]  q;
        logic [ELA_W-1:0] el;
    } run_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    function automatic logic [31:0] sat32(input logic [WIDE_W-1:0] v);
        logic [31:0] r;
        r = (v[WIDE_W-1:32] != '0) ? '1 : v[31:0];
        return r;
    endfunction

    function automatic logic [39:0] sat40(input logic [WIDE_W-1:0] v);
        logic [39:0] r;
        r = (v[WIDE_W-1:40] != '0) ? '1 : v[39:0];
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/dms_fifo.sv */
// Two-entry queue of closed runs between front and back.
// Depends on dms_pkg.
`default_nettype none
module dms_fifo
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  dms_pkg::run_t  push_data,
    output logic           full,
    input  wire            pop,
    output dms_pkg::run_t  pop_data,
    output logic           empty
);
    import dms_pkg::*;

    run_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

/* sv/dms_front.sv */
// Front end: takes duration beats, keeps count, sum and sum of squares,
// and pushes the closed run into the queue on the last beat. Uses dms_pkg.
`default_nettype none
module dms_front
#(
    parameter int MAX_RECORDS   = 1024,
    parameter int DURATION_BITS = 24
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      take,
    input  wire [dms_pkg::DUR_W-1:0] duration,
    input  wire                      last,
    input  wire [dms_pkg::ELA_W-1:0] elapsed_ticks,
    output logic                     push,
    output dms_pkg::run_t            push_data
);
    import dms_pkg::*;

    localparam logic [DUR_W-1:0] DMASK = (DURATION_BITS >= DUR_W) ? '1 :
        DUR_W'((64'd1 << DURATION_BITS) - 64'd1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]  sq_reg,  sq_next;
    logic             ovf_reg, ovf_next;
    logic [DUR_W-1:0] d;
    logic [2*DUR_W-1:0] dsq;

    always_comb
    begin
        d        = duration & DMASK;
        dsq      = d * d;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        ovf_next = ovf_reg;
        if ({21'd0, cnt_reg} < 32'(MAX_RECORDS))
        begin
            cnt_next = cnt_reg + 1'b1;
            sum_next = sum_reg + SUM_W'(d);
            sq_next  = sq_reg + SQ_W'(dsq);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign push         = take && last;
    assign push_data.ovf = ovf_next;
    assign push_data.n   = cnt_next;
    assign push_data.s   = sum_next;
    assign push_data.q   = sq_next;
    assign push_data.el  = elapsed_ticks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
                sq_reg  <= sq_next;
                ovf_reg <= ovf_next;
            end
        end
    end
endmodule
`default_nettype wire

/* sv/dms_alu.sv */
// Shared serial unit: shift-add multiply, restoring divide, digit-by-digit
// square root, one bit per cycle. Uses dms_pkg.
`default_nettype none
module dms_alu
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  dms_pkg::alu_ctl_t          ctl,
    input  wire [dms_pkg::WIDE_W-1:0]  a,
    input  wire [dms_pkg::HALF_W-1:0]  b,
    output logic                       done,
    output logic [dms_pkg::WIDE_W-1:0] res
);
    import dms_pkg::*;

    alu_op_t           op_reg;
    logic              busy_reg;
    logic [6:0]        cnt_reg;
    logic              done_reg;
    logic [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0] mc_reg;
    logic [HALF_W-1:0] mp_reg;
    logic [HALF_W+1:0] rem_reg;
    logic [HALF_W-1:0] root_reg;

    logic [HALF_W+1:0] dtrial, strial, stv;

    assign dtrial = {rem_reg[HALF_W:0], mc_reg[HALF_W-1]};
    assign strial = {rem_reg[HALF_W-1:0], mc_reg[WIDE_W-1 -: 2]};
    assign stv    = {root_reg, 2'b01};

    assign done = done_reg;
    assign res  = (op_reg == OP_MUL) ? acc_reg : {{(WIDE_W-HALF_W){1'b0}}, root_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg   <= ctl.op;
            acc_reg  <= '0;
            mc_reg   <= a;
            mp_reg   <= b;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (mp_reg[0])
                    begin
                        acc_reg <= acc_reg + mc_reg;
                    end
                    mc_reg <= mc_reg << 1;
                    mp_reg <= mp_reg >> 1;
                end
                OP_DIV:
                begin
                    if (dtrial >= {2'b00, mp_reg})
                    begin
                        rem_reg  <= dtrial - {2'b00, mp_reg};
                        root_reg <= {root_reg[HALF_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= dtrial;
                        root_reg <= {root_reg[HALF_W-2:0], 1'b0};
                    end
                    mc_reg <= mc_reg << 1;
                end
                OP_SQRT:
                begin
                    if (strial >= stv)
                    begin
                        rem_reg  <= strial - stv;
                        root_reg <= {root_reg[HALF_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= strial;
                        root_reg <= {root_reg[HALF_W-2:0], 1'b0};
                    end
                    mc_reg <= mc_reg << 2;
                end
                default:
                begin
                    mc_reg <= mc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 7'(ALU_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/dms_back.sv */
// Back end: sequences the serial unit through the statistics of one run
// and holds the result beat until taken. Uses dms_pkg and dms_alu.
`default_nettype none
module dms_back
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       q_empty,
    input  dms_pkg::run_t             q_data,
    output logic                      q_pop,
    input  wire [dms_pkg::TPS_W-1:0]  tps,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [223:0]              m_tdata,
    output logic                      m_tuser
);
    import dms_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_NSS    = 4'd1;
    localparam logic [3:0] S_SS     = 4'd2;
    localparam logic [3:0] S_MQ8    = 4'd3;
    localparam logic [3:0] S_SQ1    = 4'd4;
    localparam logic [3:0] S_SDQ8   = 4'd5;
    localparam logic [3:0] S_DN     = 4'd6;
    localparam logic [3:0] S_SU     = 4'd7;
    localparam logic [3:0] S_MUS    = 4'd8;
    localparam logic [3:0] S_VT     = 4'd9;
    localparam logic [3:0] S_SQ2    = 4'd10;
    localparam logic [3:0] S_SDUS   = 4'd11;
    localparam logic [3:0] S_SP     = 4'd12;
    localparam logic [3:0] S_PCT    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]        state_reg, state_next;
    run_t              run_reg;
    logic [69:0]       v_reg;
    logic [44:0]       dn_reg;
    logic [31:0]       mq8_reg, sq8_reg, pct_reg;
    logic [39:0]       mus_reg, sus_reg;
    logic              valid_reg;

    alu_ctl_t          ctl;
    logic [WIDE_W-1:0] alu_a;
    logic [HALF_W-1:0] alu_b;
    logic              alu_done;
    logic [WIDE_W-1:0] alu_res;
    logic              n_zero, tps_zero;
    logic [69:0]       v_sub;

    dms_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .a     (alu_a),
        .b     (alu_b),
        .done  (alu_done),
        .res   (alu_res)
    );

    assign n_zero   = (run_reg.n == '0);
    assign tps_zero = (tps == '0);
    // n*sumsq sits in v_reg while s*s comes out of the unit
    assign v_sub    = (v_reg >= alu_res[69:0]) ? v_reg - alu_res[69:0] : '0;

    always_comb
    begin
        state_next = state_reg;
        ctl.start  = 1'b0;
        ctl.op     = OP_MUL;
        alu_a      = '0;
        alu_b      = '0;
        q_pop      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ctl.start  = 1'b1;
                    alu_a      = WIDE_W'(q_data.q);
                    alu_b      = HALF_W'(q_data.n);
                    state_next = S_NSS;
                end
            end
            S_NSS:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    alu_a      = WIDE_W'(run_reg.s);
                    alu_b      = HALF_W'(run_reg.s);
                    state_next = S_SS;
                end
            end
            S_SS:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = OP_DIV;
                    alu_a      = WIDE_W'({run_reg.s, 8'd0});
                    alu_b      = HALF_W'(run_reg.n);
                    state_next = S_MQ8;
                end
            end
            S_MQ8:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = OP_SQRT;
                    alu_a      = WIDE_W'({v_reg, 16'd0});
                    state_next = S_SQ1;
                end
            end
            S_SQ1:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = OP_DIV;
                    alu_a      = alu_res;
                    alu_b      = HALF_W'(run_reg.n);
                    state_next = S_SDQ8;
                end
            end
            S_SDQ8:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    alu_a      = WIDE_W'(run_reg.n);
                    alu_b      = HALF_W'(tps);
                    state_next = S_DN;
                end
            end
            S_DN:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    alu_a      = WIDE_W'(run_reg.s);
                    alu_b      = USEC_SCALE;
                    state_next = S_SU;
                end
            end
            S_SU:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = OP_DIV;
                    alu_a      = alu_res;
                    alu_b      = HALF_W'(dn_reg);
                    state_next = S_MUS;
                end
            end
            S_MUS:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    alu_a      = WIDE_W'(v_reg);
                    alu_b      = USEC_SCALE_SQ;
                    state_next = S_VT;
                end
            end
            S_VT:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = OP_SQRT;
                    alu_a      = alu_res;
                    state_next = S_SQ2;
                end
            end
            S_SQ2:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = OP_DIV;
                    alu_a      = alu_res;
                    alu_b      = HALF_W'(dn_reg);
                    state_next = S_SDUS;
                end
            end
            S_SDUS:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    alu_a      = WIDE_W'(run_reg.s);
                    alu_b      = PCT_SCALE;
                    state_next = S_SP;
                end
            end
            S_SP:
            begin
                if (alu_done)
                begin
                    ctl.start  = 1'b1;
                    ctl.op     = OP_DIV;
                    alu_a      = alu_res;
                    alu_b      = HALF_W'(run_reg.el);
                    state_next = S_PCT;
                end
            end
            S_PCT:
            begin
                if (alu_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // payload captures
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            run_reg <= q_data;
        end
        if (alu_done)
        begin
            case (state_reg)
                S_NSS:  v_reg   <= alu_res[69:0];
                S_SS:   v_reg   <= v_sub;
                S_MQ8:  mq8_reg <= n_zero ? '0 : sat32(alu_res);
                S_SDQ8: sq8_reg <= n_zero ? '0 : sat32(alu_res);
                S_DN:   dn_reg  <= alu_res[44:0];
                S_MUS:  mus_reg <= tps_zero ? '1 : (n_zero ? '0 : sat40(alu_res));
                S_SDUS: sus_reg <= tps_zero ? '1 : (n_zero ? '0 : sat40(alu_res));
                S_PCT:  pct_reg <= (run_reg.el == '0) ? '1 : sat32(alu_res);
                default: dn_reg <= dn_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_next == S_OUT);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = run_reg.ovf;
    assign m_tdata  = {3'd0, pct_reg, sus_reg, mus_reg, sq8_reg, mq8_reg, run_reg.s, run_reg.n};
endmodule
`default_nettype wire

/* sv/duration_mean_stddev_stats.sv */
// Detour duration statistics: population mean and standard deviation.
// Top level; depends on dms_pkg, dms_front, dms_fifo, dms_back, dms_alu.
//
// Usage:
//  - s_* channel: one duration per beat; tlast closes the run and that
//    beat also carries the run's elapsed ticks.
//  - m_* channel: one result beat per run (status in tuser).
//  - cfg_wr_en/cfg_wr_data write ticks_per_sec; write only while idle.
// Throughput: the front takes one duration per cycle. It stalls any beat
// while both queue entries hold runs not yet started.
// Sequence: a closed run takes 13 passes of the serial unit (multiply,
// divide, square root one bit per cycle); with the back idle, the queue
// pop starts the first pass, and result valid rises once the last pass
// is done.
// The back handles one run at a time; that serial unit sets the rate of
// runs, not of durations.
// Reset: clears the accumulators, queue, sequencer and output valid;
// ticks_per_sec returns to 1e9.
// Stall: a result waiting on m_tready holds the back, while the front keeps
// accumulating and queuing up to two more closed runs.
`default_nettype none
module duration_mean_stddev_stats
#(
    parameter int MAX_RECORDS   = 1024,
    parameter int DURATION_BITS = 24
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [71:0]  s_tdata,   // duration[23:0], elapsed_ticks[71:24]
    input  wire          s_tlast,   // last
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [223:0] m_tdata,   // record_count[10:0], sum_ticks[44:11],
                                    // mean_ticks_q8[76:45], std_ticks_q8[108:77],
                                    // mean_usec_q16[148:109], std_usec_q16[188:149],
                                    // detour_percent_q16[220:189], zero pad
    output logic         m_tuser,   // status
    input  wire          cfg_wr_en,
    input  wire  [33:0]  cfg_wr_data
);
    import dms_pkg::*;

    logic [TPS_W-1:0] tps_reg;
    logic             take;
    logic             push, full, pop, empty;
    run_t             push_data, pop_data;

    // tick rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            tps_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    dms_front
    #(
        .MAX_RECORDS   (MAX_RECORDS),
        .DURATION_BITS (DURATION_BITS)
    )
    u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .duration      (s_tdata[23:0]),
        .last          (s_tlast),
        .elapsed_ticks (s_tdata[71:24]),
        .push          (push),
        .push_data     (push_data)
    );

    dms_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    dms_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (empty),
        .q_data   (pop_data),
        .q_pop    (pop),
        .tps      (tps_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

/* sim/duration_mean_stddev_stats_tb.sv */
// Self-checking testbench for duration_mean_stddev_stats.
// Depends on dms_pkg and the block's RTL. It predicts each run's statistics
// with an exact wide-integer model and checks every result beat against it.
`default_nettype none
module duration_mean_stddev_stats_tb;
    import dms_pkg::*;

    localparam int MAX_RUN     = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 1200;   // a bit over one run's latency
    localparam logic [TPS_W-1:0] TPS_MIN = 34'd1000000;
    localparam logic [TPS_W-1:0] TPS_MAX = 34'd10000000000;

    // one result beat, fields as unpacked from m_tdata/m_tuser
    typedef struct packed {
        logic        status;
        logic [10:0] record_count;
        logic [33:0] sum_ticks;
        logic [31:0] mean_ticks_q8;
        logic [31:0] std_ticks_q8;
        logic [39:0] mean_usec_q16;
        logic [39:0] std_usec_q16;
        logic [31:0] detour_percent_q16;
    } run_stats_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [71:0]   s_tdata;     // duration[23:0], elapsed_ticks[71:24]
    logic          s_tlast;     // last
    logic          m_tvalid;
    logic          m_tready;
    logic [223:0]  m_tdata;     // count, sum, mean, std, mean_us, std_us, pct, pad
    logic          m_tuser;     // status
    logic          cfg_wr_en;
    logic [33:0]   cfg_wr_data;

    // shadow of the accumulators and the tick rate
    int               acc_count;
    logic [SUM_W-1:0] acc_sum;
    logic [SQ_W-1:0]  acc_sumsq;
    logic             acc_overflow;
    logic [TPS_W-1:0] tick_rate;

    run_stats_t expected_stats[$];
    int         errors;
    int         cycles;
    int         hold_left;      // long receiver stall, counted down per cycle
    int         rx_gap_left;
    bit         no_idle;        // stretch with both sides idle-free

    duration_mean_stddev_stats dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("duration_mean_stddev_stats_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [39:0] clamp_to(input logic [159:0] x, input int w);
        logic [159:0] lim;
        lim = (160'd1 << w) - 160'd1;
        return (x > lim) ? lim[39:0] : x[39:0];
    endfunction

    function automatic logic [159:0] int_sqrt(input logic [159:0] x);
        logic [159:0] root;
        logic [159:0] cand;
        root = '0;
        for (int k = 79; k >= 0; k--)
        begin
            cand = root | (160'd1 << k);
            if (cand * cand <= x)
                root = cand;
        end
        return root;
    endfunction

    // Accumulate one accepted beat; on a closing beat queue the run's stats.
    task automatic predict_beat(input logic [23:0] dur, input bit lst,
                                input logic [47:0] elapsed);
        logic [159:0] n, s, v, nss, ss, dn;
        run_stats_t   r;
        if (acc_count < MAX_RUN)
        begin
            acc_count++;
            acc_sum   = acc_sum + dur;
            acc_sumsq = acc_sumsq + ({34'd0, dur} * {34'd0, dur});
        end
        else
            acc_overflow = 1'b1;
        if (!lst)
            return;
        n   = acc_count;
        s   = acc_sum;
        nss = n * acc_sumsq;
        ss  = s * s;
        v   = (nss >= ss) ? nss - ss : '0;
        r.status        = acc_overflow;
        r.record_count  = acc_count[10:0];
        r.sum_ticks     = acc_sum;
        r.mean_ticks_q8 = 32'(clamp_to((s << 8) / n, 32));
        r.std_ticks_q8  = 32'(clamp_to(int_sqrt(v << 16) / n, 32));
        dn = n * tick_rate;
        if (dn == 0)
        begin
            r.mean_usec_q16 = '1;
            r.std_usec_q16  = '1;
        end
        else
        begin
            r.mean_usec_q16 = clamp_to(s * USEC_SCALE / dn, 40);
            r.std_usec_q16  = clamp_to(int_sqrt(v * USEC_SCALE * USEC_SCALE) / dn, 40);
        end
        if (elapsed == 0)
            r.detour_percent_q16 = '1;
        else
            r.detour_percent_q16 = 32'(clamp_to(s * PCT_SCALE / elapsed, 32));
        expected_stats.push_back(r);
        acc_count    = 0;
        acc_sum      = '0;
        acc_sumsq    = '0;
        acc_overflow = 1'b0;
    endtask

    // Offer one beat after a random gap, or none while no_idle is set; returns right after it is accepted.
    task automatic send_beat(input logic [23:0] dur, input bit lst,
                             input logic [47:0] elapsed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {elapsed, dur};
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        predict_beat(dur, lst, elapsed);
    endtask

    task automatic go_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    task automatic wait_drained();
        go_quiet();
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tick_rate = rate;
    endtask

    function automatic logic [23:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] pick_elapsed();
        case ($urandom_range(0, 3))
            0:       return 48'({$urandom, $urandom});
            1:       return 48'($urandom_range(1, 1 << 20));
            default: return {16'd0, $urandom} | 48'd1;
        endcase
    endfunction

    task automatic send_run(input int len, input logic [47:0] elapsed);
        for (int i = 0; i < len; i++)
            send_beat(pick_duration(), i == len - 1, elapsed);
    endtask

    // result checker
    always
    begin
        run_stats_t got, want;
        @(negedge clk);
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (rx_gap_left > 0)
        begin
            m_tready <= 1'b0;
            rx_gap_left--;
        end
        else
            m_tready <= 1'b1;
        @(posedge clk);
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[10:0], m_tdata[44:11], m_tdata[76:45],
                   m_tdata[108:77], m_tdata[148:109], m_tdata[188:149],
                   m_tdata[220:189]};
            if (expected_stats.size() == 0)
            begin
                $error("result beat with no run pending");
                errors++;
            end
            else
            begin
                want = expected_stats.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.record_count !== want.record_count)
                begin
                    $error("record_count exp %0d got %0d", want.record_count,
                           got.record_count);
                    errors++;
                end
                if (got.sum_ticks !== want.sum_ticks)
                begin
                    $error("sum_ticks exp %0d got %0d", want.sum_ticks, got.sum_ticks);
                    errors++;
                end
                if (got.mean_ticks_q8 !== want.mean_ticks_q8)
                begin
                    $error("mean_ticks_q8 exp %0d got %0d", want.mean_ticks_q8,
                           got.mean_ticks_q8);
                    errors++;
                end
                if (got.std_ticks_q8 !== want.std_ticks_q8)
                begin
                    $error("std_ticks_q8 exp %0d got %0d", want.std_ticks_q8,
                           got.std_ticks_q8);
                    errors++;
                end
                if (got.mean_usec_q16 !== want.mean_usec_q16)
                begin
                    $error("mean_usec_q16 exp %0d got %0d", want.mean_usec_q16,
                           got.mean_usec_q16);
                    errors++;
                end
                if (got.std_usec_q16 !== want.std_usec_q16)
                begin
                    $error("std_usec_q16 exp %0d got %0d", want.std_usec_q16,
                           got.std_usec_q16);
                    errors++;
                end
                if (got.detour_percent_q16 !== want.detour_percent_q16)
                begin
                    $error("detour_percent_q16 exp %0d got %0d",
                           want.detour_percent_q16, got.detour_percent_q16);
                    errors++;
                end
            end
            rx_gap_left = no_idle ? 0 : $urandom_range(0, 12);
        end
    end

    // Field extremes, equal values (zero deviation), zero elapsed,
    // saturated percent, all at the reset tick rate.
    task automatic test_field_extremes();
        send_beat(24'd0, 1'b1, 48'd1);
        send_beat('1, 1'b1, 48'd1);
        send_beat(24'd0, 1'b0, '1);
        send_beat('1, 1'b1, '1);
        send_beat(24'd12345, 1'b1, 48'd0);
        for (int i = 0; i < 3; i++)
            send_beat(24'd777, i == 2, 48'd5000);
        send_beat(24'h5a5a5a, 1'b0, 48'h5a5a5a5a5a5a);
        send_beat(24'ha5a5a5, 1'b1, 48'ha5a5a5a5a5a5);
    endtask

    // Tick rate at its range ends, zero and all ones.
    task automatic test_tick_rates();
        logic [TPS_W-1:0] rates[4];
        rates = '{TPS_MIN, TPS_MAX, '0, '1};
        foreach (rates[i])
        begin
            write_tick_rate(rates[i]);
            send_beat('1, 1'b0, 48'd1000);
            send_beat(24'd1, 1'b1, 48'd1000);
        end
        write_tick_rate(TPS_RESET);
    endtask

    // A run that overruns and drops its tail, the closing beat included.
    task automatic test_run_too_long();
        no_idle = 1'b1;
        send_run(MAX_RUN + 6, 48'd1 << 40);
        no_idle = 1'b0;
    endtask

    task automatic test_random_runs();
        int sent;
        int len;
        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_tick_rate(phase == 0 ? TPS_RESET :
                            TPS_MIN + TPS_W'({$urandom_range(0, 1), $urandom}));
            no_idle = (phase == 2);
            while (sent < (phase + 1) * 75)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120)
                                                  : $urandom_range(1, 12);
                send_run(len, pick_elapsed());
                sent += len;
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver stalls long while runs keep arriving: queue fills, input stalls.
    task automatic test_output_stall();
        wait_drained();
        hold_left = 5000;
        for (int i = 0; i < 6; i++)
            send_run(3, pick_elapsed());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        errors       = 0;
        cycles       = 0;
        hold_left    = 0;
        rx_gap_left  = 0;
        no_idle      = 1'b0;
        acc_count    = 0;
        acc_sum      = '0;
        acc_sumsq    = '0;
        acc_overflow = 1'b0;
        tick_rate    = TPS_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_tick_rates();
        test_run_too_long();
        test_random_runs();
        test_output_stall();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && expected_stats.size() == 0)
            $display("duration_mean_stddev_stats_tb OK");
        else
            $display("duration_mean_stddev_stats_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

/* duration_mean_stddev_stats.f */
sv/dms_pkg.sv
sv/dms_fifo.sv
sv/dms_front.sv
sv/dms_alu.sv
sv/dms_back.sv
sv/duration_mean_stddev_stats.sv
sim/duration_mean_stddev_stats_tb.sv
